>>> sv/smae_pkg.sv
// shared types and constants for the square matrix arithmetic engine
package smae_pkg;

  localparam int ROW_W = 3;
  localparam int DIM_W = 4;
  localparam int VAL_W = 32;
  localparam int RES_W = 64;
  localparam int IN_TDATA_W = 40;
  localparam int OUT_TDATA_W = 72;
  localparam int REQ_W = 2;
  localparam int MODE_W = 2;
  localparam int CFG_IDX_W = 2;

  localparam logic [MODE_W-1:0] MODE_MATMUL = 2'd0;
  localparam logic [MODE_W-1:0] MODE_MATVEC = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SCALE = 2'd2;
  localparam logic [MODE_W-1:0] MODE_ADD = 2'd3;

  localparam logic [REQ_W-1:0] REQ_LOAD_A = 2'd0;
  localparam logic [REQ_W-1:0] REQ_LOAD_B = 2'd1;
  localparam logic [REQ_W-1:0] REQ_START = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_OP_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DIM = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE = 2'd2;

  localparam logic [DIM_W-1:0] DIM_RESET = 4'd8;
  localparam logic [VAL_W-1:0] SCALE_RESET = 32'd1;

  typedef struct packed {
    logic valid;
    logic first;
    logic done;
    logic last;
    logic [ROW_W-1:0] row;
    logic [ROW_W-1:0] col;
  } term_tag_t;

endpackage

>>> sv/square_matrix_arith_engine.sv
// top level of the square matrix arithmetic engine
// Load requests write one element of A or B and are taken one per cycle while idle.
// A start request runs the selected operation through one shared multiply/add unit
// that handles one product term per cycle, unless the output stalls, behind a
// registered store read: a matrix product has dim^3 terms, matrix-vector dim^2,
// scale and sum dim^2. After the last term come the product register, the result
// register and the transfer of the last result, and input ready stays low from
// start until the last result of the run has been taken.
module square_matrix_arith_engine #(
  parameter int MAX_DIM = 8
) (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  input  logic [smae_pkg::IN_TDATA_W-1:0] s_axis_tdata, // row, col, value
  input  logic [smae_pkg::REQ_W-1:0] s_axis_tuser,      // req_type
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  output logic [smae_pkg::OUT_TDATA_W-1:0] m_axis_tdata, // result, out_row, out_col
  output logic m_axis_tlast,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [smae_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [smae_pkg::VAL_W-1:0] cfg_data
);
  import smae_pkg::*;

  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [MODE_W-1:0] op_mode;
  logic [DIM_W-1:0] dim, n;
  logic [VAL_W-1:0] scale;
  logic [ROW_W-1:0] in_row, in_col;
  logic [VAL_W-1:0] in_value;
  logic in_acc, in_range, wr_a, wr_b, start, en, final_taken, idle;
  logic [AW-1:0] wr_addr, a_addr, b_addr;
  logic [VAL_W-1:0] a_data, b_data;
  term_tag_t tag;

  assign in_row = s_axis_tdata[ROW_W-1:0];
  assign in_col = s_axis_tdata[2*ROW_W-1:ROW_W];
  assign in_value = s_axis_tdata[2*ROW_W+VAL_W-1:2*ROW_W];

  assign s_axis_tready = idle;
  assign in_acc = s_axis_tvalid && s_axis_tready;
  assign in_range = (int'(in_row) < MAX_DIM) && (int'(in_col) < MAX_DIM);
  assign wr_a = in_acc && in_range && (s_axis_tuser == REQ_LOAD_A);
  assign wr_b = in_acc && in_range && (s_axis_tuser == REQ_LOAD_B);
  assign start = in_acc && (s_axis_tuser == REQ_START);
  assign wr_addr = AW'(int'(in_row) * MAX_DIM + int'(in_col));

  assign en = !(m_axis_tvalid && !m_axis_tready);
  assign final_taken = m_axis_tvalid && m_axis_tready && m_axis_tlast;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      op_mode <= MODE_MATMUL;
      dim <= DIM_RESET;
      scale <= SCALE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_OP_MODE: op_mode <= cfg_data[MODE_W-1:0];
        CFG_DIM: dim <= cfg_data[DIM_W-1:0];
        CFG_SCALE: scale <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (dim == '0) begin
      n = DIM_W'(1);
    end else if (int'(dim) > MAX_DIM) begin
      n = DIM_W'(MAX_DIM);
    end else begin
      n = dim;
    end
  end

  smae_store #(.DEPTH(DEPTH)) u_store_a (
    .clk(clk),
    .wr_en(wr_a),
    .wr_addr(wr_addr),
    .wr_data(in_value),
    .rd_en(en),
    .rd_addr(a_addr),
    .rd_data(a_data)
  );

  smae_store #(.DEPTH(DEPTH)) u_store_b (
    .clk(clk),
    .wr_en(wr_b),
    .wr_addr(wr_addr),
    .wr_data(in_value),
    .rd_en(en),
    .rd_addr(b_addr),
    .rd_data(b_data)
  );

  smae_seq #(.MAX_DIM(MAX_DIM)) u_seq (
    .clk(clk),
    .rst(rst),
    .start(start),
    .en(en),
    .final_taken(final_taken),
    .op_mode(op_mode),
    .n(n),
    .idle(idle),
    .a_addr(a_addr),
    .b_addr(b_addr),
    .tag(tag)
  );

  smae_mac u_mac (
    .clk(clk),
    .rst(rst),
    .en(en),
    .op_mode(op_mode),
    .scale(scale),
    .tag(tag),
    .a_data(a_data),
    .b_data(b_data),
    .out_ready(m_axis_tready),
    .out_valid(m_axis_tvalid),
    .out_data(m_axis_tdata),
    .out_last(m_axis_tlast)
  );

endmodule

>>> sv/smae_store.sv
// one matrix store with a write port and a registered read port
module smae_store #(
  parameter int DEPTH = 64
) (
  input  logic                    clk,
  input  logic                    wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [smae_pkg::VAL_W-1:0] wr_data,
  input  logic                    rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [smae_pkg::VAL_W-1:0] rd_data
);
  import smae_pkg::*;

  logic [VAL_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> sv/smae_seq.sv
// sequencer that walks rows, columns and product terms of a run
module smae_seq #(
  parameter int MAX_DIM = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic                  en,
  input  logic                  final_taken,
  input  logic [smae_pkg::MODE_W-1:0] op_mode,
  input  logic [smae_pkg::DIM_W-1:0]  n,
  output logic                  idle,
  output logic [((MAX_DIM * MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1)-1:0] a_addr,
  output logic [((MAX_DIM * MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1)-1:0] b_addr,
  output smae_pkg::term_tag_t   tag
);
  import smae_pkg::*;

  localparam int AW = (MAX_DIM * MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1;
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;

  logic [1:0] state;
  logic [ROW_W-1:0] i, k, j;
  logic dot_mode;
  logic [DIM_W-1:0] nterms, ncols;
  logic term_end, col_end, row_end, issue;
  logic [ROW_W-1:0] a_col, b_row, b_col;
  term_tag_t tag_next;

  assign idle = (state == ST_IDLE);
  assign issue = (state == ST_RUN) && en;
  assign dot_mode = (op_mode == MODE_MATMUL) || (op_mode == MODE_MATVEC);
  assign nterms = dot_mode ? n : DIM_W'(1);
  assign ncols = (op_mode == MODE_MATVEC) ? DIM_W'(1) : n;
  assign term_end = (DIM_W'(j) + DIM_W'(1)) == nterms;
  assign col_end = (DIM_W'(k) + DIM_W'(1)) == ncols;
  assign row_end = (DIM_W'(i) + DIM_W'(1)) == n;

  assign a_col = dot_mode ? j : k;
  always_comb begin
    unique case (op_mode)
      MODE_MATMUL: begin
        b_row = j;
        b_col = k;
      end
      MODE_MATVEC: begin
        b_row = '0;
        b_col = j;
      end
      default: begin
        b_row = i;
        b_col = k;
      end
    endcase
  end

  assign a_addr = AW'(int'(i) * MAX_DIM + int'(a_col));
  assign b_addr = AW'(int'(b_row) * MAX_DIM + int'(b_col));

  always_comb begin
    tag_next.valid = issue;
    tag_next.first = (j == '0);
    tag_next.done = term_end;
    tag_next.last = term_end && col_end && row_end;
    tag_next.row = i;
    tag_next.col = k;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      i <= '0;
      k <= '0;
      j <= '0;
      tag <= '0;
    end else begin
      if (en) begin
        tag <= tag_next;
      end
      unique case (state)
        ST_IDLE: begin
          i <= '0;
          k <= '0;
          j <= '0;
          if (start) begin
            state <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (en) begin
            if (!term_end) begin
              j <= j + 1'b1;
            end else begin
              j <= '0;
              if (!col_end) begin
                k <= k + 1'b1;
              end else begin
                k <= '0;
                if (row_end) begin
                  state <= ST_DRAIN;
                end else begin
                  i <= i + 1'b1;
                end
              end
            end
          end
        end
        ST_DRAIN: begin
          if (final_taken) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

>>> sv/smae_mac.sv
// shared multiply or add unit with accumulator and output register
module smae_mac (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic [smae_pkg::MODE_W-1:0] op_mode,
  input  logic [smae_pkg::VAL_W-1:0]  scale,
  input  smae_pkg::term_tag_t       tag,
  input  logic [smae_pkg::VAL_W-1:0]  a_data,
  input  logic [smae_pkg::VAL_W-1:0]  b_data,
  input  logic                      out_ready,
  output logic                      out_valid,
  output logic [smae_pkg::OUT_TDATA_W-1:0] out_data,
  output logic                      out_last
);
  import smae_pkg::*;

  logic signed [VAL_W-1:0] a_s, b_s;
  logic signed [RES_W-1:0] p_next, prod, acc, acc_next, res;
  term_tag_t tag2;
  logic [ROW_W-1:0] res_row, res_col;

  assign a_s = signed'(a_data);
  assign b_s = (op_mode == MODE_SCALE) ? signed'(scale) : signed'(b_data);

  always_comb begin
    if (op_mode == MODE_ADD) begin
      p_next = RES_W'(a_s) + RES_W'(b_s);
    end else begin
      p_next = RES_W'(a_s) * RES_W'(b_s);
    end
  end

  assign acc_next = tag2.first ? prod : acc + prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      tag2 <= '0;
      out_valid <= 1'b0;
    end else begin
      if (en) begin
        tag2 <= tag;
      end
      if (en && tag2.valid && tag2.done) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= p_next;
      if (tag2.valid) begin
        acc <= acc_next;
        if (tag2.done) begin
          res <= acc_next;
          res_row <= tag2.row;
          res_col <= tag2.col;
          out_last <= tag2.last;
        end
      end
    end
  end

  assign out_data = {(OUT_TDATA_W - RES_W - 2 * ROW_W)'(0), res_col, res_row, res};

endmodule
